[hw/rtl/kalman_cv_2d_tracker_assert.svh]
// Assertion macros for the constant-velocity tracker checker.
`ifndef KALMAN_CV_2D_TRACKER_ASSERT_SVH
`define KALMAN_CV_2D_TRACKER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define KCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/kct_pkg.sv]
// Shared constants, types and helper functions of the constant-velocity tracker.
`timescale 1ns / 1ps
package kct_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int REG_W     = 31;
   localparam int NUM_REGS  = 7;
   localparam int CSR_IDX_W = 3;
   localparam int RAM_DEPTH = 128;
   localparam int ADDR_W    = 7;
   localparam int ACC_W     = 66 - FRAC_BITS;
   localparam int SAT_W     = ACC_W + 2;
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int DIV_W     = (NUM_W > ACC_W) ? NUM_W : ACC_W;
   localparam int DCNT_W    = $clog2(NUM_W);

   localparam logic signed [DATA_W-1:0] FX_ONE   = DATA_W'(1 << FRAC_BITS);
   localparam logic signed [DATA_W-1:0] P_INIT   = DATA_W'(100 << FRAC_BITS);
   localparam logic signed [63:0]       PROD_HALF = 64'(1) << (FRAC_BITS - 1);
   localparam logic [REG_W-1:0]         REG_RESET = REG_W'(1 << FRAC_BITS);
   localparam logic signed [SAT_W-1:0]  SAT_HI   = SAT_W'(2147483647);
   localparam logic signed [SAT_W-1:0]  SAT_LO   = ~SAT_HI;

   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROC_X    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PROC_XDOT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PROC_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PROC_YDOT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MEAS_X    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MEAS_Y    = 3'd6;

   // scratch memory map
   localparam logic [ADDR_W-1:0] P_BASE     = 7'd0;
   localparam logic [ADDR_W-1:0] XH_BASE    = 7'd16;
   localparam logic [ADDR_W-1:0] M1_BASE    = 7'd36;
   localparam logic [ADDR_W-1:0] PP_BASE    = 7'd52;
   localparam logic [ADDR_W-1:0] XP_BASE    = 7'd68;
   localparam logic [ADDR_W-1:0] SINV_BASE  = 7'd72;
   localparam logic [ADDR_W-1:0] K_BASE     = 7'd76;
   localparam logic [ADDR_W-1:0] INNOV_BASE = 7'd84;
   localparam logic [ADDR_W-1:0] S_BASE     = 7'd86;
   localparam int               CLR_LAST   = 19;

   localparam logic [3:0] PH_XP    = 4'd0;
   localparam logic [3:0] PH_M1    = 4'd1;
   localparam logic [3:0] PH_PP    = 4'd2;
   localparam logic [3:0] PH_S     = 4'd3;
   localparam logic [3:0] PH_DET   = 4'd4;
   localparam logic [3:0] PH_K     = 4'd5;
   localparam logic [3:0] PH_INNOV = 4'd6;
   localparam logic [3:0] PH_KY    = 4'd7;
   localparam logic [3:0] PH_KHP   = 4'd8;

   localparam logic [1:0] BSEL_RAM = 2'd0;
   localparam logic [1:0] BSEL_ONE = 2'd1;
   localparam logic [1:0] BSEL_AT  = 2'd2;

   localparam logic [1:0] POST_NONE = 2'd0;
   localparam logic [1:0] POST_ADD  = 2'd1;
   localparam logic [1:0] POST_SUB  = 2'd2;

   localparam logic [1:0] PSRC_REG = 2'd0;
   localparam logic [1:0] PSRC_Z   = 2'd1;
   localparam logic [1:0] PSRC_RAM = 2'd2;

   typedef struct packed {
      logic [1:0]        n_last;
      logic [1:0]        m_last;
      logic [1:0]        p_last;
      logic              a_mat;
      logic [1:0]        b_sel;
      logic [ADDR_W-1:0] a_base;
      logic [ADDR_W-1:0] a_ri;
      logic [ADDR_W-1:0] a_rj;
      logic [ADDR_W-1:0] a_rk;
      logic [ADDR_W-1:0] b_base;
      logic [ADDR_W-1:0] b_rj;
      logic [ADDR_W-1:0] b_rk;
      logic [ADDR_W-1:0] d_base;
      logic [ADDR_W-1:0] d_ri;
      logic [ADDR_W-1:0] q_base;
      logic [ADDR_W-1:0] q_ri;
      logic              dst_en;
      logic [1:0]        post_op;
      logic [1:0]        post_src;
      logic              diag_only;
      logic              neg_odd;
   } phase_type;

   function automatic phase_type phase_info(input logic [3:0] ph);
      phase_type p;
      p = '0;
      p.dst_en = 1'b1;
      case (ph)
         PH_XP: begin
            p.n_last = 2'd3; p.m_last = 2'd3; p.a_mat = 1'b1;
            p.b_base = XH_BASE; p.b_rk = 7'd1;
            p.d_base = XP_BASE; p.d_ri = 7'd1;
         end
         PH_M1: begin
            p.n_last = 2'd3; p.m_last = 2'd3; p.p_last = 2'd3; p.a_mat = 1'b1;
            p.b_base = P_BASE; p.b_rk = 7'd4; p.b_rj = 7'd1;
            p.d_base = M1_BASE; p.d_ri = 7'd4;
         end
         PH_PP: begin
            p.n_last = 2'd3; p.m_last = 2'd3; p.p_last = 2'd3;
            p.a_base = M1_BASE; p.a_ri = 7'd4; p.a_rk = 7'd1; p.b_sel = BSEL_AT;
            p.d_base = PP_BASE; p.d_ri = 7'd4;
            p.post_op = POST_ADD; p.post_src = PSRC_REG; p.diag_only = 1'b1;
            p.q_base = 7'(REG_PROC_X);
         end
         PH_S: begin
            p.n_last = 2'd1; p.p_last = 2'd1;
            p.a_base = PP_BASE; p.a_ri = 7'd8; p.a_rj = 7'd2; p.b_sel = BSEL_ONE;
            p.d_base = S_BASE; p.d_ri = 7'd2;
            p.post_op = POST_ADD; p.post_src = PSRC_REG; p.diag_only = 1'b1;
            p.q_base = 7'(REG_MEAS_X);
         end
         PH_DET: begin
            p.m_last = 2'd1; p.dst_en = 1'b0; p.neg_odd = 1'b1;
            p.a_base = S_BASE; p.a_rk = 7'd1;
            p.b_base = S_BASE + 7'd3; p.b_rk = 7'h7f;
         end
         PH_K: begin
            p.n_last = 2'd3; p.m_last = 2'd1; p.p_last = 2'd1;
            p.a_base = PP_BASE; p.a_ri = 7'd4; p.a_rk = 7'd2;
            p.b_base = SINV_BASE; p.b_rk = 7'd2; p.b_rj = 7'd1;
            p.d_base = K_BASE; p.d_ri = 7'd2;
         end
         PH_INNOV: begin
            p.n_last = 2'd1;
            p.a_base = XP_BASE; p.a_ri = 7'd2; p.b_sel = BSEL_ONE;
            p.d_base = INNOV_BASE; p.d_ri = 7'd1;
            p.post_op = POST_SUB; p.post_src = PSRC_Z;
         end
         PH_KY: begin
            p.n_last = 2'd3; p.m_last = 2'd1;
            p.a_base = K_BASE; p.a_ri = 7'd2; p.a_rk = 7'd1;
            p.b_base = INNOV_BASE; p.b_rk = 7'd1;
            p.d_base = XH_BASE; p.d_ri = 7'd1;
            p.post_op = POST_ADD; p.post_src = PSRC_RAM;
            p.q_base = XP_BASE; p.q_ri = 7'd1;
         end
         PH_KHP: begin
            p.n_last = 2'd3; p.m_last = 2'd1; p.p_last = 2'd3;
            p.a_base = K_BASE; p.a_ri = 7'd2; p.a_rk = 7'd1;
            p.b_base = PP_BASE; p.b_rk = 7'd8; p.b_rj = 7'd1;
            p.d_base = P_BASE; p.d_ri = 7'd4;
            p.post_op = POST_SUB; p.post_src = PSRC_RAM;
            p.q_base = PP_BASE; p.q_ri = 7'd4;
         end
         default: p.dst_en = 1'b0;
      endcase
      return p;
   endfunction

   // entry (r, c) of the transition matrix
   function automatic logic signed [DATA_W-1:0] amat(input logic [1:0] r,
                                                     input logic [1:0] c,
                                                     input logic [REG_W-1:0] dt);
      logic signed [DATA_W-1:0] v;
      v = '0;
      if (r == c) v = FX_ONE;
      else if ((r == 2'd0 && c == 2'd1) || (r == 2'd2 && c == 2'd3)) v = {1'b0, dt};
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [SAT_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_HI) r = SAT_HI[DATA_W-1:0];
      else if (v < SAT_LO) r = SAT_LO[DATA_W-1:0];
      else r = v[DATA_W-1:0];
      return r;
   endfunction

   // address of the adjugate entry for inverse entry e, stored as s00 s01 s10 s11
   function automatic logic [ADDR_W-1:0] num_addr(input logic [1:0] e);
      logic [ADDR_W-1:0] a;
      case (e)
         2'd0:    a = S_BASE + 7'd3;
         2'd1:    a = S_BASE + 7'd1;
         2'd2:    a = S_BASE + 7'd2;
         default: a = S_BASE;
      endcase
      return a;
   endfunction

endpackage

[hw/rtl/kct_stream_if.sv]
// Request and response channel interfaces of the tracker.
`timescale 1ns / 1ps
interface kct_req_if;
   import kct_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] meas_x;
   logic signed [DATA_W-1:0] meas_y;
   modport source (output valid, meas_x, meas_y, input ready);
   modport sink (input valid, meas_x, meas_y, output ready);
endinterface

interface kct_rsp_if;
   import kct_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] est_x;
   logic signed [DATA_W-1:0] est_y;
   modport source (output valid, est_x, est_y, input ready);
   modport sink (input valid, est_x, est_y, output ready);
endinterface

[hw/rtl/kct_ram.sv]
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module kct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data <= mem_ff[rd_a_addr];
      rd_b_data <= mem_ff[rd_b_addr];
   end
endmodule

[hw/rtl/kalman_cv_2d_tracker.sv]
// Top level of the constant-velocity 2D Kalman tracker.
`timescale 1ns / 1ps
// One request (a measured x,y position) runs one predict/update step of a
// four-state constant-velocity Kalman filter and returns one response with the
// filtered x,y position. All matrix work goes through a single 32x32
// multiply-accumulate unit stepped by a sequencer over a 128-entry scratch RAM:
// each product term is read, multiplied and accumulated, and each result entry
// is post-processed and written, 208 terms and 71 entries in all, and the four
// inverse entries go through a one-bit-per-cycle divider, which is skipped when
// the determinant is zero. The next request is taken while the response waits.
// After reset a clearing pass loads the covariance and estimate before the first
// request is taken.
module kalman_cv_2d_tracker (
   input  logic                          clock,
   input  logic                          reset,
   kct_req_if.sink                       req_ch,
   kct_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [kct_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kct_pkg::REG_W-1:0]     csr_wdata
);
   import kct_pkg::*;

   localparam logic [3:0] ST_CLR  = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_RD   = 4'd2;
   localparam logic [3:0] ST_MUL  = 4'd3;
   localparam logic [3:0] ST_ACC  = 4'd4;
   localparam logic [3:0] ST_PRD  = 4'd5;
   localparam logic [3:0] ST_POST = 4'd6;
   localparam logic [3:0] ST_DRD  = 4'd7;
   localparam logic [3:0] ST_DLD  = 4'd8;
   localparam logic [3:0] ST_DIT  = 4'd9;
   localparam logic [3:0] ST_DWR  = 4'd10;
   localparam logic [3:0] ST_FIN  = 4'd11;

   logic [3:0]               state_ff, state_in;
   logic [3:0]               phase_ff, phase_in;
   logic [1:0]               i_ff, i_in, j_ff, j_in, k_ff, k_in, e_ff, e_in;
   logic [4:0]               clr_ff, clr_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, det_ff, det_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [DATA_W-1:0] zx_ff, zx_in, zy_ff, zy_in;
   logic signed [DATA_W-1:0] est_x_ff, est_x_in, est_y_ff, est_y_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [REG_W-1:0]         reg_ff [NUM_REGS];
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [NUM_W-1:0]         num_ff, num_in, quo_ff, quo_in;
   logic [DCNT_W-1:0]        dcnt_ff, dcnt_in;
   logic                     qneg_ff, qneg_in;

   phase_type                ph;
   logic [ADDR_W-1:0]        a_addr, b_addr, d_addr, q_addr, rd_a_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [DATA_W-1:0]        wr_data, ram_a_rd, ram_b_rd;
   logic signed [DATA_W-1:0] opa, opb, post_val, post_res, sat_acc, div_res;
   logic signed [63:0]       rnd_sum, rnd;
   logic signed [ACC_W-1:0]  term;
   logic signed [SAT_W-1:0]  post_sum;
   logic                     post_on, req_take;
   logic [CSR_IDX_W-1:0]     reg_idx;
   logic [DATA_W-1:0]        num_mag;
   logic [DIV_W-1:0]         den_mag;
   logic [DIV_W:0]           trial;
   logic [ADDR_W-1:0]        i_ext, j_ext, k_ext;

   kct_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (ram_a_rd),
      .rd_b_addr (b_addr),
      .rd_b_data (ram_b_rd)
   );

   assign ph    = phase_info(phase_ff);
   assign i_ext = ADDR_W'(i_ff);
   assign j_ext = ADDR_W'(j_ff);
   assign k_ext = ADDR_W'(k_ff);

   assign a_addr = ph.a_base + ph.a_ri * i_ext + ph.a_rj * j_ext + ph.a_rk * k_ext;
   assign b_addr = ph.b_base + ph.b_rj * j_ext + ph.b_rk * k_ext;
   assign d_addr = ph.d_base + ph.d_ri * i_ext + j_ext;
   assign q_addr = ph.q_base + ph.q_ri * i_ext + j_ext;

   always_comb begin
      rd_a_addr = a_addr;
      if (state_ff == ST_PRD) rd_a_addr = q_addr;
      else if (state_ff == ST_DRD) rd_a_addr = num_addr(e_ff);
   end

   // operand select and rounding
   assign opa = ph.a_mat ? amat(i_ff, k_ff, reg_ff[REG_TIME_STEP]) : $signed(ram_a_rd);
   always_comb begin
      case (ph.b_sel)
         BSEL_ONE: opb = FX_ONE;
         BSEL_AT:  opb = amat(j_ff, k_ff, reg_ff[REG_TIME_STEP]);
         default:  opb = $signed(ram_b_rd);
      endcase
   end
   assign prod_in = opa * opb;
   assign rnd_sum = prod_ff + PROD_HALF;
   assign rnd     = rnd_sum >>> FRAC_BITS;
   assign term    = (ph.neg_odd && k_ff[0]) ? -ACC_W'(rnd) : ACC_W'(rnd);

   // entry post-processing
   assign sat_acc = sat_wide(SAT_W'(acc_ff));
   assign reg_idx = CSR_IDX_W'(ph.q_base) + CSR_IDX_W'(i_ff);
   always_comb begin
      case (ph.post_src)
         PSRC_REG: post_val = $signed({1'b0, reg_ff[reg_idx]});
         PSRC_Z:   post_val = i_ff[0] ? zy_ff : zx_ff;
         default:  post_val = $signed(ram_a_rd);
      endcase
   end
   assign post_on = (ph.post_op != POST_NONE) && (!ph.diag_only || i_ff == j_ff);
   assign post_sum = (ph.post_op == POST_SUB) ? SAT_W'(post_val) - SAT_W'(sat_acc)
                                              : SAT_W'(post_val) + SAT_W'(sat_acc);
   assign post_res = post_on ? sat_wide(post_sum) : sat_acc;

   // divider datapath
   assign num_mag = ram_a_rd[DATA_W-1] ? -ram_a_rd : ram_a_rd;
   assign den_mag = DIV_W'(unsigned'(det_ff[ACC_W-1] ? -det_ff : det_ff));
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   always_comb begin
      if (qneg_ff) begin
         if (quo_ff > NUM_W'(33'h080000000)) div_res = SAT_LO[DATA_W-1:0];
         else div_res = -$signed(quo_ff[DATA_W-1:0]);
      end else begin
         if (quo_ff > NUM_W'(SAT_HI[DATA_W-1:0])) div_res = SAT_HI[DATA_W-1:0];
         else div_res = $signed(quo_ff[DATA_W-1:0]);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = d_addr;
      wr_data = post_res;
      unique case (state_ff)
         ST_CLR: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(clr_ff);
            wr_data = (!clr_ff[4] && clr_ff[1:0] == clr_ff[3:2]) ? P_INIT : '0;
         end
         ST_POST: wr_en = ph.dst_en;
         ST_DWR: begin
            wr_en   = 1'b1;
            wr_addr = SINV_BASE + ADDR_W'(e_ff);
            wr_data = div_res;
         end
         default: wr_en = 1'b0;
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; e_in = e_ff;
      clr_in = clr_ff;
      acc_in = acc_ff;
      det_in = det_ff;
      zx_in = zx_ff; zy_in = zy_ff;
      est_x_in = est_x_ff; est_y_in = est_y_ff;
      rem_in = rem_ff; num_in = num_ff; quo_in = quo_ff;
      dcnt_in = dcnt_ff; qneg_in = qneg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_x_in = rsp_x_ff; rsp_y_in = rsp_y_ff;
      unique case (state_ff)
         ST_CLR: begin
            clr_in = clr_ff + 5'd1;
            if (clr_ff == 5'(CLR_LAST)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) begin
               zx_in = req_ch.meas_x;
               zy_in = req_ch.meas_y;
               phase_in = PH_XP;
               i_in = '0; j_in = '0; k_in = '0;
               acc_in = '0;
               state_in = ST_RD;
            end
         end
         ST_RD:  state_in = ST_MUL;
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            acc_in = acc_ff + term;
            if (k_ff == ph.m_last) state_in = ST_PRD;
            else begin
               k_in = k_ff + 2'd1;
               state_in = ST_RD;
            end
         end
         ST_PRD: state_in = ST_POST;
         ST_POST: begin
            if (phase_ff == PH_DET) det_in = acc_ff;
            if (phase_ff == PH_KY && i_ff == 2'd0) est_x_in = post_res;
            if (phase_ff == PH_KY && i_ff == 2'd2) est_y_in = post_res;
            acc_in = '0;
            k_in = '0;
            state_in = ST_RD;
            if (j_ff == ph.p_last) begin
               j_in = '0;
               if (i_ff == ph.n_last) begin
                  i_in = '0;
                  if (phase_ff == PH_DET) begin
                     e_in = '0;
                     state_in = ST_DRD;
                  end else if (phase_ff == PH_KHP) begin
                     state_in = ST_FIN;
                  end else begin
                     phase_in = phase_ff + 4'd1;
                  end
               end else begin
                  i_in = i_ff + 2'd1;
               end
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         ST_DRD: state_in = ST_DLD;
         ST_DLD: begin
            num_in  = {num_mag, FRAC_BITS'(0)};
            qneg_in = ram_a_rd[DATA_W-1] ^ (e_ff == 2'd1 || e_ff == 2'd2) ^ det_ff[ACC_W-1];
            rem_in  = '0;
            quo_in  = '0;
            dcnt_in = DCNT_W'(NUM_W - 1);
            state_in = (det_ff == '0) ? ST_DWR : ST_DIT;
         end
         ST_DIT: begin
            num_in = num_ff << 1;
            if (trial >= {1'b0, den_mag}) begin
               rem_in = DIV_W'(trial - {1'b0, den_mag});
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIV_W-1:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == '0) state_in = ST_DWR;
         end
         ST_DWR: begin
            e_in = e_ff + 2'd1;
            if (e_ff == 2'd3) begin
               phase_in = PH_K;
               state_in = ST_RD;
            end else begin
               state_in = ST_DRD;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = est_x_ff;
               rsp_y_in = est_y_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         phase_ff     <= PH_XP;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         e_ff         <= '0;
         clr_ff       <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         e_ff         <= e_in;
         clr_ff       <= clr_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      det_ff   <= det_in;
      prod_ff  <= prod_in;
      zx_ff    <= zx_in;
      zy_ff    <= zy_in;
      est_x_ff <= est_x_in;
      est_y_ff <= est_y_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      qneg_ff  <= qneg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_REGS; n++) reg_ff[n] <= REG_RESET;
      end else if (csr_wr_en && csr_index < CSR_IDX_W'(NUM_REGS)) begin
         reg_ff[csr_index] <= csr_wdata;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.est_x = rsp_x_ff;
   assign rsp_ch.est_y = rsp_y_ff;
endmodule

[hw/rtl/kct_checker.sv]
// Port-level checker of the tracker and its bind to the top level.
`timescale 1ns / 1ps
`include "kalman_cv_2d_tracker_assert.svh"
module kct_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [kct_pkg::DATA_W-1:0] rsp_est_x,
   input logic [kct_pkg::DATA_W-1:0] rsp_est_y
);
   import kct_pkg::*;

   `KCT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `KCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_est_x) && $stable(rsp_est_y), "stalled response changed")
   `KCT_ASSERT(a_rsp_from_busy, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "response while idle")
endmodule

bind kalman_cv_2d_tracker kct_checker u_kct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_est_x (rsp_ch.est_x),
   .rsp_est_y (rsp_ch.est_y)
);

[bench/kalman_cv_2d_tracker_tb.sv]
// Self-checking testbench for the constant-velocity 2D Kalman tracker.
`timescale 1ns / 1ps
module kalman_cv_2d_tracker_tb;
   import kct_pkg::*;

   localparam logic [CSR_IDX_W-1:0] IDX_UNUSED    = 3'd7;
   localparam longint ONE_L  = longint'(1) << FRAC_BITS;
   localparam longint HALF_L = longint'(1) << (FRAC_BITS - 1);
   localparam longint MAX_L  = 64'sd2147483647;
   localparam longint MIN_L  = -64'sd2147483648;
   localparam logic [REG_W-1:0] REG_MAX = 31'h7fffffff;

   typedef longint mat_type[16];
   typedef struct packed {
      logic signed [DATA_W-1:0] est_x;
      logic signed [DATA_W-1:0] est_y;
   } track_pos_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0] csr_wdata;

   kct_req_if req_bus();
   kct_rsp_if rsp_bus();

   kalman_cv_2d_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   longint        cfg_reg[NUM_REGS];
   longint        est_vec[4];
   mat_type       cov_mat;
   track_pos_type pending_pos[$];
   int            mismatches;
   bit            quiet;
   int            hold_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic longint sat32(input longint v);
      if (v > MAX_L) return MAX_L;
      if (v < MIN_L) return MIN_L;
      return v;
   endfunction

   function automatic longint rmul(input longint a, input longint b);
      return (a * b + HALF_L) >>> FRAC_BITS;
   endfunction

   function automatic void mat_mul(input mat_type a, input mat_type b, output mat_type c,
                                   input int n, input int m, input int p);
      longint acc;
      c = '{default: 0};
      for (int i = 0; i < n; i++)
         for (int j = 0; j < p; j++) begin
            acc = 0;
            for (int k = 0; k < m; k++) acc += rmul(a[i*m+k], b[k*p+j]);
            c[i*p+j] = sat32(acc);
         end
   endfunction

   function automatic void reset_filter();
      for (int i = 0; i < NUM_REGS; i++) cfg_reg[i] = ONE_L;
      est_vec = '{default: 0};
      cov_mat = '{default: 0};
      for (int i = 0; i < 4; i++) cov_mat[i*5] = 100 * ONE_L;
   endfunction

   function automatic track_pos_type filter_step(input logic signed [DATA_W-1:0] zx,
                                                 input logic signed [DATA_W-1:0] zy);
      mat_type a, at, m1, pp, kh, khp, xh, xp, pht, sinv, kg, innov, ky;
      longint s00, s01, s10, s11, det;
      track_pos_type r;
      a = '{default: 0};
      for (int i = 0; i < 4; i++) a[i*5] = ONE_L;
      a[1] = cfg_reg[REG_TIME_STEP];
      a[11] = cfg_reg[REG_TIME_STEP];
      for (int i = 0; i < 16; i++) at[(i % 4) * 4 + i / 4] = a[i];
      xh = '{default: 0};
      for (int i = 0; i < 4; i++) xh[i] = est_vec[i];
      mat_mul(a, xh, xp, 4, 4, 1);
      mat_mul(a, cov_mat, m1, 4, 4, 4);
      mat_mul(m1, at, pp, 4, 4, 4);
      for (int i = 0; i < 4; i++) pp[i*5] = sat32(pp[i*5] + cfg_reg[1+i]);
      s00 = sat32(pp[0] + cfg_reg[REG_MEAS_X]);
      s01 = pp[2];
      s10 = pp[8];
      s11 = sat32(pp[10] + cfg_reg[REG_MEAS_Y]);
      det = rmul(s00, s11) - rmul(s01, s10);
      sinv = '{default: 0};
      if (det != 0) begin
         sinv[0] = sat32((s11 * ONE_L) / det);
         sinv[1] = sat32((-s01 * ONE_L) / det);
         sinv[2] = sat32((-s10 * ONE_L) / det);
         sinv[3] = sat32((s00 * ONE_L) / det);
      end
      pht = '{default: 0};
      for (int i = 0; i < 4; i++) begin
         pht[i*2] = pp[i*4];
         pht[i*2+1] = pp[i*4+2];
      end
      mat_mul(pht, sinv, kg, 4, 2, 2);
      innov = '{default: 0};
      innov[0] = sat32(longint'(zx) - xp[0]);
      innov[1] = sat32(longint'(zy) - xp[2]);
      mat_mul(kg, innov, ky, 4, 2, 1);
      for (int i = 0; i < 4; i++) est_vec[i] = sat32(xp[i] + ky[i]);
      kh = '{default: 0};
      for (int i = 0; i < 4; i++) begin
         kh[i*4] = kg[i*2];
         kh[i*4+2] = kg[i*2+1];
      end
      mat_mul(kh, pp, khp, 4, 4, 4);
      for (int i = 0; i < 16; i++) cov_mat[i] = sat32(pp[i] - khp[i]);
      r.est_x = est_vec[0][DATA_W-1:0];
      r.est_y = est_vec[2][DATA_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx < NUM_REGS) cfg_reg[idx] = longint'(val);
   endtask

   task automatic write_all(input logic [REG_W-1:0] dt, input logic [REG_W-1:0] qp,
                            input logic [REG_W-1:0] qv, input logic [REG_W-1:0] rv);
      write_reg(REG_TIME_STEP, dt);
      write_reg(REG_PROC_X, qp);
      write_reg(REG_PROC_XDOT, qv);
      write_reg(REG_PROC_Y, qp);
      write_reg(REG_PROC_YDOT, qv);
      write_reg(REG_MEAS_X, rv);
      write_reg(REG_MEAS_Y, rv);
   endtask

   task automatic send_request(input logic signed [DATA_W-1:0] mx,
                               input logic signed [DATA_W-1:0] my);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.meas_x = mx;
      req_bus.meas_y = my;
      do @(posedge clock); while (!req_bus.ready);
      pending_pos.push_back(filter_step(mx, my));
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_pos.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            hold_cycles--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      track_pos_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pos.size() == 0) begin
            report_mismatch("unexpected response est_x", rsp_bus.est_x, 0);
         end else begin
            want = pending_pos.pop_front();
            if (rsp_bus.est_x !== want.est_x)
               report_mismatch("est_x", rsp_bus.est_x, want.est_x);
            if (rsp_bus.est_y !== want.est_y)
               report_mismatch("est_y", rsp_bus.est_y, want.est_y);
         end
      end
   end

   task automatic test_reset_defaults();
      send_request(32'sd0, 32'sd0);
      send_request(32'sd65536, -32'sd65536);
      send_request(32'sh7fffffff, 32'sh80000000);
      send_request(32'sh80000000, 32'sh7fffffff);
      send_request(32'sd1, -32'sd1);
      wait_idle();
   endtask

   task automatic test_extreme_regs();
      write_all(REG_MAX, REG_MAX, REG_MAX, REG_MAX);
      write_reg(IDX_UNUSED, 31'd12345);
      send_request(32'sh7fffffff, 32'sh7fffffff);
      send_request(32'sh80000000, 32'sh80000000);
      send_request(32'sh7fffffff, 32'sh80000000);
      send_request(32'sd0, 32'sd0);
      wait_idle();
      write_all(REG_MAX, 31'd0, 31'd0, 31'd0);
      send_request(32'sh7fffffff, 32'sh80000000);
      send_request(32'sh80000000, 32'sh7fffffff);
      send_request(32'sh12345678, -32'sh12345678);
      wait_idle();
   endtask

   task automatic test_zero_determinant();
      write_all(31'd0, 31'd0, 31'd0, 31'd0);
      for (int i = 0; i < 8; i++) send_request($urandom, $urandom);
      wait_idle();
      write_all(31'd0, 31'd100, 31'd0, 31'd0);
      for (int i = 0; i < 4; i++) send_request($urandom, $urandom);
      wait_idle();
   endtask

   task automatic test_backpressure();
      write_all(31'd65536, 31'd6554, 31'd6554, 31'd65536);
      hold_cycles = 4000;
      for (int i = 0; i < 4; i++) send_request(i * 32'sd131072, -i * 32'sd65536);
      wait_idle();
   endtask

   task automatic test_random_tracks(input int phases, input int per_phase);
      longint px, py, vx, vy;
      int amp;
      logic signed [DATA_W-1:0] mx, my;
      for (int ph = 0; ph < phases; ph++) begin
         if (ph == phases - 1) quiet = 1'b1;
         write_all(REG_W'($urandom_range(600, 200000)), REG_W'($urandom_range(0, 70000)),
                   REG_W'($urandom_range(0, 70000)), REG_W'($urandom_range(1, 400000)));
         if ($urandom_range(0, 1)) write_reg(REG_PROC_Y, REG_W'($urandom));
         px = longint'($urandom_range(0, 2000000)) - 1000000;
         py = longint'($urandom_range(0, 2000000)) - 1000000;
         vx = longint'($urandom_range(0, 400000)) - 200000;
         vy = longint'($urandom_range(0, 400000)) - 200000;
         amp = $urandom_range(1, 100000);
         for (int i = 0; i < per_phase; i++) begin
            px += vx;
            py += vy;
            if ($urandom_range(0, 9) == 0) begin
               mx = $urandom;
               my = $urandom;
            end else begin
               mx = DATA_W'(px + longint'($urandom_range(0, 2 * amp)) - amp);
               my = DATA_W'(py + longint'($urandom_range(0, 2 * amp)) - amp);
            end
            send_request(mx, my);
         end
         wait_idle();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.meas_x = '0;
      req_bus.meas_y = '0;
      mismatches = 0;
      quiet = 1'b0;
      hold_cycles = 0;
      reset_filter();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_extreme_regs();
      test_zero_determinant();
      test_backpressure();
      test_random_tracks(6, 80);
      wait_idle();
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
